### sv/ttc_emergency_brake_check_macros.svh
// Assertion helpers shared by the checking code of the brake check.
`ifndef TTC_EMERGENCY_BRAKE_CHECK_MACROS_SVH
`define TTC_EMERGENCY_BRAKE_CHECK_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TEBC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TEBC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/tebc_pkg.sv
package tebc_pkg;

    localparam int unsigned MAX_BEAMS       = 2048;
    localparam int unsigned COS_TABLE_DEPTH = 256;
    localparam int unsigned COS_IDX_W       = $clog2(COS_TABLE_DEPTH + 1);

    localparam longint unsigned PI_Q30 = 64'd3373259426;
    localparam longint          ONE_Q30 = 64'sd1073741824;

    localparam logic [13:0] THRESHOLD_RST = 14'd600;
    localparam logic [15:0] FLOOR_RST     = 16'd0;
    localparam logic [15:0] CEILING_RST   = 16'd65535;
    localparam logic [15:0] ANG_START_RST = 16'h8000;
    localparam logic [11:0] ANG_STEP_RST  = 12'd61;

    typedef enum logic [2:0] {
        REG_THRESHOLD = 3'd0,
        REG_FLOOR     = 3'd1,
        REG_CEILING   = 3'd2,
        REG_ANG_START = 3'd3,
        REG_ANG_STEP  = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic load_beam;
        logic load_speed;
        logic tab;
        logic mul;
        logic cls;
        logic cmp;
    } t_cmd;

    typedef struct packed {
        logic last;
        logic out_free;
    } t_sts;

    typedef logic [14:0] t_cos_tab [0:COS_TABLE_DEPTH];

    // Quarter-wave cosine entry in unsigned Q0.15, from an eleven-term Taylor series in Q30.
    function automatic logic [14:0] cos_entry(int unsigned k);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        x    = (longint'(k) * PI_Q30) / (2 * COS_TABLE_DEPTH);
        x2   = (x * x) >> 30;
        term = longint'(ONE_Q30);
        sum  = ONE_Q30;
        term = ((term * x2) >> 30) / 2;   sum = sum - longint'(term);
        term = ((term * x2) >> 30) / 12;  sum = sum + longint'(term);
        term = ((term * x2) >> 30) / 30;  sum = sum - longint'(term);
        term = ((term * x2) >> 30) / 56;  sum = sum + longint'(term);
        term = ((term * x2) >> 30) / 90;  sum = sum - longint'(term);
        term = ((term * x2) >> 30) / 132; sum = sum + longint'(term);
        term = ((term * x2) >> 30) / 182; sum = sum - longint'(term);
        term = ((term * x2) >> 30) / 240; sum = sum + longint'(term);
        term = ((term * x2) >> 30) / 306; sum = sum - longint'(term);
        term = ((term * x2) >> 30) / 380; sum = sum + longint'(term);
        if (sum < 0) begin
            sum = 0;
        end
        sum = (sum + 16384) >>> 15;
        if (sum > 32767) begin
            sum = 32767;
        end
        return sum[14:0];
    endfunction

    function automatic t_cos_tab cos_build();
        t_cos_tab tab;
        for (int unsigned k = 0; k <= COS_TABLE_DEPTH; k++) begin
            tab[k] = cos_entry(k);
        end
        return tab;
    endfunction

    localparam t_cos_tab COS_TAB = cos_build();

endpackage

### sv/tebc_ctrl.sv
module tebc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_kind,
    output logic          o_in_ready,
    input  tebc_pkg::t_sts i_sts,
    output tebc_pkg::t_cmd o_cmd
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_TAB  = 5'b00010,
        ST_MUL  = 5'b00100,
        ST_CLS  = 5'b01000,
        ST_CMP  = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   cmp_go;

    assign cmp_go = (r_state == ST_CMP) && (!i_sts.last || i_sts.out_free);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid && i_in_kind) begin
                    n_state = ST_TAB;
                end
            end
            ST_TAB:  n_state = ST_MUL;
            ST_MUL:  n_state = ST_CLS;
            ST_CLS:  n_state = ST_CMP;
            ST_CMP: begin
                if (cmp_go) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready       = (r_state == ST_IDLE);
    assign o_cmd.load_beam  = (r_state == ST_IDLE) && i_in_valid && i_in_kind;
    assign o_cmd.load_speed = (r_state == ST_IDLE) && i_in_valid && !i_in_kind;
    assign o_cmd.tab        = (r_state == ST_TAB);
    assign o_cmd.mul        = (r_state == ST_MUL);
    assign o_cmd.cls        = (r_state == ST_CLS);
    assign o_cmd.cmp        = cmp_go;

endmodule

### sv/tebc_dp.sv
module tebc_dp #(
    parameter int unsigned MAX_BEAMS = tebc_pkg::MAX_BEAMS
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_valid,
    input  logic [2:0]     i_cfg_index,
    input  logic [15:0]    i_cfg_data,
    input  logic [15:0]    i_speed,
    input  logic [15:0]    i_range,
    input  logic           i_nan,
    input  logic           i_last,
    input  tebc_pkg::t_cmd i_cmd,
    output tebc_pkg::t_sts o_sts,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output logic           o_out_alarm
);

    localparam int unsigned IW = $clog2(MAX_BEAMS);
    localparam int unsigned CW = tebc_pkg::COS_IDX_W;

    logic [13:0]        r_thr;
    logic [15:0]        r_floor;
    logic [15:0]        r_ceil;
    logic [15:0]        r_start;
    logic [11:0]        r_step;

    logic signed [15:0] r_speed;
    logic [IW-1:0]      r_idx;
    logic [IW-1:0]      n_idx;
    logic               r_alarm;

    logic [15:0]        r_ang;
    logic [25:0]        r_lhs;
    logic               r_vld;
    logic               r_last;
    logic signed [15:0] r_cos;
    logic signed [31:0] r_prod;
    logic [28:0]        r_rhs;
    logic               r_out_valid;
    logic               r_out_alarm;

    logic [IW+11:0]     ang_prod;
    logic [13+CW:0]     tab_scaled;
    logic [CW-1:0]      tab_i;
    logic [CW-1:0]      tab_j;
    logic [14:0]        cos_mag;
    logic               cos_neg;
    logic [14:0]        closing;
    logic               trip;
    logic               n_alarm;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr   <= tebc_pkg::THRESHOLD_RST;
            r_floor <= tebc_pkg::FLOOR_RST;
            r_ceil  <= tebc_pkg::CEILING_RST;
            r_start <= tebc_pkg::ANG_START_RST;
            r_step  <= tebc_pkg::ANG_STEP_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                tebc_pkg::REG_THRESHOLD: r_thr   <= i_cfg_data[13:0];
                tebc_pkg::REG_FLOOR:     r_floor <= i_cfg_data;
                tebc_pkg::REG_CEILING:   r_ceil  <= i_cfg_data;
                tebc_pkg::REG_ANG_START: r_start <= i_cfg_data;
                tebc_pkg::REG_ANG_STEP:  r_step  <= i_cfg_data[11:0];
                default: ;
            endcase
        end
    end

    assign ang_prod = (IW + 12)'(r_idx) * (IW + 12)'(r_step);

    always_comb begin
        priority if (i_last) begin
            n_idx = '0;
        end else if (r_idx == IW'(MAX_BEAMS - 1)) begin
            n_idx = '0;
        end else begin
            n_idx = r_idx + IW'(1);
        end
    end

    assign tab_scaled = (14 + CW)'(r_ang[13:0]) * (14 + CW)'(tebc_pkg::COS_TABLE_DEPTH);
    assign tab_i      = tab_scaled[13+CW:14];
    assign tab_j      = CW'(tebc_pkg::COS_TABLE_DEPTH) - tab_i;

    always_comb begin
        unique case (r_ang[15:14])
            2'd0: begin cos_mag = tebc_pkg::COS_TAB[tab_i]; cos_neg = 1'b0; end
            2'd1: begin cos_mag = tebc_pkg::COS_TAB[tab_j]; cos_neg = 1'b1; end
            2'd2: begin cos_mag = tebc_pkg::COS_TAB[tab_i]; cos_neg = 1'b1; end
            2'd3: begin cos_mag = tebc_pkg::COS_TAB[tab_j]; cos_neg = 1'b0; end
            default: begin cos_mag = '0; cos_neg = 1'b0; end
        endcase
    end

    assign closing = (r_prod >= 32'sd32768) ? r_prod[29:15] : 15'd1;
    assign trip    = r_vld && ({3'b000, r_lhs} < r_rhs);
    assign n_alarm = r_alarm || trip;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_beam) begin
            r_ang  <= r_start + ang_prod[15:0];
            r_lhs  <= 26'(i_range) * 26'd1000;
            r_vld  <= !i_nan && (i_range >= r_floor) && (i_range <= r_ceil);
            r_last <= i_last;
        end
        if (i_cmd.tab) begin
            r_cos <= cos_neg ? -$signed({1'b0, cos_mag}) : $signed({1'b0, cos_mag});
        end
        if (i_cmd.mul) begin
            r_prod <= 32'(r_speed) * 32'(r_cos);
        end
        if (i_cmd.cls) begin
            r_rhs <= 29'(r_thr) * 29'(closing);
        end
        if (i_cmd.cmp && r_last) begin
            r_out_alarm <= n_alarm;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed     <= '0;
            r_idx       <= '0;
            r_alarm     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load_speed) begin
                r_speed <= $signed(i_speed);
            end
            if (i_cmd.load_beam) begin
                r_idx <= n_idx;
            end
            if (i_cmd.cmp) begin
                r_alarm <= r_last ? 1'b0 : n_alarm;
            end
            if (i_cmd.cmp && r_last) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.last     = r_last;
    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_out_alarm    = r_out_alarm;

endmodule

### sv/ttc_emergency_brake_check.sv
// Beam request: accepted in idle, then cosine lookup, speed multiply, threshold
// multiply and compare run in turn; a last beam's result is registered at compare,
// which waits for a free output register. No request is taken until the beam ends.
// A speed request is accepted in idle. A finished result waits in an output register.
// Synchronous active-low reset restores register defaults and clears speed, index, flag.
// The cosine table is constant logic, so no clearing pass follows reset.
`include "ttc_emergency_brake_check_macros.svh"

module ttc_emergency_brake_check #(
    parameter int unsigned MAX_BEAMS = tebc_pkg::MAX_BEAMS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // speed_mm_s[15:0], range_mm[31:16], range_is_nan[32]
    input  logic        s_axis_tuser,  // kind
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata   // brake_alarm[0]
);

    tebc_pkg::t_cmd cmd;
    tebc_pkg::t_sts sts;
    logic           out_alarm;

    assign o_cfg_ready = 1'b1;

    tebc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_kind  (s_axis_tuser),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    tebc_dp #(
        .MAX_BEAMS (MAX_BEAMS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_speed     (s_axis_tdata[15:0]),
        .i_range     (s_axis_tdata[31:16]),
        .i_nan       (s_axis_tdata[32]),
        .i_last      (s_axis_tlast),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_alarm (out_alarm)
    );

    assign m_axis_tdata = {7'b0000000, out_alarm};

    `TEBC_ASSERT_NEXT(a_beam_starts_lookup, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready && s_axis_tuser, cmd.tab && !s_axis_tready, "beam request did not start the lookup step")
    `TEBC_ASSERT_SAME(a_busy_blocks_input, i_clk, i_rst_n, cmd.tab || cmd.mul || cmd.cls || cmd.cmp, !s_axis_tready, "input ready while a beam is in flight")
    `TEBC_ASSERT_SAME(a_no_result_overwrite, i_clk, i_rst_n, cmd.cmp && sts.last, !m_axis_tvalid || m_axis_tready, "result would overwrite an untaken result")
    `TEBC_ASSERT_NEXT(a_last_gives_result, i_clk, i_rst_n, cmd.cmp && sts.last, m_axis_tvalid, "last beam gave no result")

endmodule
